// ===== hw/rtl/sa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sa_pkg
// Shared types, constants and helpers for the slot allocator with key lookup.
// ----------------------------------------------------------------------------
package sa_pkg;

    // pool geometry
    localparam int NUM_SLOTS = 16;
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // fixed field widths
    localparam int OP_W   = 2;
    localparam int SLOT_W = 6;
    localparam int HALF_W = 32;
    localparam int KEY_W  = 2 * HALF_W;
    localparam int CNT_W  = 7;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_WALK   = 2'd3
    } t_op;

    typedef logic [NUM_SLOTS-1:0] t_mask;
    typedef logic [IDX_W-1:0]     t_idx;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;  // latch a new transaction
        logic exec;     // resolve the latched transaction
        logic step;     // emit the next walk entry
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic last;     // the result being emitted ends the transaction
        logic walk;     // latched transaction is a walk
    } t_dp_status;

    // index of the lowest set bit, zero when none
    function automatic t_idx lowest_set(input t_mask m);
        t_idx r;
        r = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (m[i]) begin
                r = t_idx'(i);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sa_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sa_ctrl
// Controller: accepts transactions and sequences resolve and walk cycles.
// ----------------------------------------------------------------------------
module sa_ctrl
    import sa_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd,
    output logic            o_busy
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    // next state and commands
    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.exec    = 1'b0;
        o_cmd.step    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = (i_status.walk && !i_status.last) ? ST_WALK : ST_IDLE;
            end
            ST_WALK: begin
                o_cmd.step = 1'b1;
                n_state    = i_status.last ? ST_IDLE : ST_WALK;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_busy = (n_state != ST_IDLE);
    end

    // state and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_busy = r_busy;

endmodule
`default_nettype wire

// ===== hw/rtl/sa_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sa_dpath
// Datapath: in-use bits, key store, busy counter, search and result registers.
// ----------------------------------------------------------------------------
module sa_dpath
    import sa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    input  wire logic [OP_W-1:0]   i_operation,
    input  wire logic [SLOT_W-1:0] i_slot_number,
    input  wire logic [HALF_W-1:0] i_source_entity,
    input  wire logic [HALF_W-1:0] i_sequence_number,
    output t_dp_status             o_status,
    output logic                   o_valid,
    output logic                   o_found,
    output logic [SLOT_W-1:0]      o_slot_result,
    output logic [CNT_W-1:0]       o_busy_count,
    output logic                   o_last
);

    // latched transaction
    t_op               r_op;
    logic [SLOT_W-1:0] r_slot;
    logic [KEY_W-1:0]  r_key;
    t_mask             r_match;

    // pool state
    t_mask             r_in_use, n_in_use;
    logic [KEY_W-1:0]  r_keys [NUM_SLOTS];
    logic [CNT_W-1:0]  r_count, n_count;
    t_mask             r_pend, n_pend;

    // result registers
    logic              r_valid;
    logic              r_found, n_found;
    logic [SLOT_W-1:0] r_slot_res, n_slot_res;
    logic [CNT_W-1:0]  r_busy_cnt, n_busy_cnt;
    logic              r_last, n_last;

    // search helpers
    t_mask             free_mask;
    t_idx              free_idx;
    t_idx              match_idx;
    t_idx              free_slot_idx;
    logic              free_in_range;
    t_mask             walk_src;
    t_idx              walk_idx;
    t_mask             walk_rest;
    logic              key_wr;

    assign free_mask     = ~r_in_use;
    assign free_idx      = lowest_set(free_mask);
    assign match_idx     = lowest_set(r_match);
    assign free_slot_idx = r_slot[IDX_W-1:0];
    assign free_in_range = ({1'b0, r_slot} < (SLOT_W + 1)'(NUM_SLOTS));
    assign walk_src      = i_cmd.exec ? r_in_use : r_pend;
    assign walk_idx      = lowest_set(walk_src);
    assign walk_rest     = walk_src & ~(t_mask'(1) << walk_idx);

    // status to controller
    assign o_status.walk = (r_op == OP_WALK);
    assign o_status.last = (r_op != OP_WALK) || (walk_rest == '0);

    // resolve the latched transaction
    always_comb begin
        n_in_use   = r_in_use;
        n_count    = r_count;
        n_pend     = r_pend;
        n_found    = 1'b0;
        n_slot_res = '0;
        n_busy_cnt = r_count;
        n_last     = 1'b1;
        key_wr     = 1'b0;
        if (i_cmd.exec || i_cmd.step) begin
            case (r_op)
                OP_ALLOC: begin
                    if (free_mask != '0) begin
                        n_in_use[free_idx] = 1'b1;
                        n_count            = r_count + CNT_W'(1);
                        n_found            = 1'b1;
                        n_slot_res         = SLOT_W'(free_idx);
                        key_wr             = 1'b1;
                    end
                    n_busy_cnt = n_count;
                end
                OP_FREE: begin
                    if (free_in_range) begin
                        n_in_use[free_slot_idx] = 1'b0;
                        n_count    = r_count - CNT_W'(r_in_use[free_slot_idx]);
                        n_found    = 1'b1;
                        n_slot_res = r_slot;
                    end
                    n_busy_cnt = n_count;
                end
                OP_LOOKUP: begin
                    if (r_match != '0) begin
                        n_found    = 1'b1;
                        n_slot_res = SLOT_W'(match_idx);
                    end
                end
                OP_WALK: begin
                    n_found    = (walk_src != '0);
                    n_slot_res = SLOT_W'(walk_idx);
                    n_last     = (walk_rest == '0);
                    n_pend     = walk_rest;
                end
                default: begin
                    n_last = 1'b1;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= '0;
            r_count  <= '0;
            r_pend   <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_in_use <= n_in_use;
            r_count  <= n_count;
            r_pend   <= n_pend;
            r_valid  <= i_cmd.exec || i_cmd.step;
        end
    end

    // transaction capture and parallel key compare
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= t_op'(i_operation);
            r_slot <= i_slot_number;
            r_key  <= {i_source_entity, i_sequence_number};
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_match[i] <= r_in_use[i] &&
                              (r_keys[i] == {i_source_entity, i_sequence_number});
            end
        end
    end

    // key store, written on allocation
    always_ff @(posedge i_clk) begin
        if (key_wr) begin
            r_keys[free_idx] <= r_key;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec || i_cmd.step) begin
            r_found    <= n_found;
            r_slot_res <= n_slot_res;
            r_busy_cnt <= n_busy_cnt;
            r_last     <= n_last;
        end
    end

    assign o_valid       = r_valid;
    assign o_found       = r_found;
    assign o_slot_result = r_slot_res;
    assign o_busy_count  = r_busy_cnt;
    assign o_last        = r_last;

endmodule
`default_nettype wire

// ===== hw/rtl/slot_allocator_with_key_lookup.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slot_allocator_with_key_lookup
// Pool of transaction slots with lowest-free allocation, free by index,
// lookup by 64-bit key and an ascending walk of the slots in use.
//
//   channel   handshake           payload
//   --------  ------------------  ---------------------------------------------
//   command   i_start / o_busy    i_operation, i_slot_number, i_source_entity,
//                                 i_sequence_number
//   result    o_valid (strobe)    o_found, o_slot_result, o_busy_count, o_last
//
// allocate, free and lookup first latch the transaction and compare the key
// against every slot, then resolve through the priority encoder and update the
// pool. a walk yields max(1, slots in use) results, one per cycle from the
// priority encoder over the pending mask.
// each result is shown for one cycle after the resolving edge; the receiver
// cannot stall. reset clears every in-use bit and the busy count.
// ----------------------------------------------------------------------------
module slot_allocator_with_key_lookup
    import sa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire logic [OP_W-1:0]   i_operation,
    input  wire logic [SLOT_W-1:0] i_slot_number,
    input  wire logic [HALF_W-1:0] i_source_entity,
    input  wire logic [HALF_W-1:0] i_sequence_number,
    output logic                   o_valid,
    output logic                   o_found,
    output logic [SLOT_W-1:0]      o_slot_result,
    output logic [CNT_W-1:0]       o_busy_count,
    output logic                   o_last
);

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       start_req;

    // a start is only seen while idle
    assign start_req = i_start && !o_busy;

    // controller
    sa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start_req),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy)
    );

    // datapath
    sa_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_operation       (i_operation),
        .i_slot_number     (i_slot_number),
        .i_source_entity   (i_source_entity),
        .i_sequence_number (i_sequence_number),
        .o_status          (status),
        .o_valid           (o_valid),
        .o_found           (o_found),
        .o_slot_result     (o_slot_result),
        .o_busy_count      (o_busy_count),
        .o_last            (o_last)
    );

endmodule
`default_nettype wire

// ===== tb/slot_allocator_with_key_lookup_checker.sv =====
// ----------------------------------------------------------------------------
// slot_allocator_with_key_lookup_checker
// Watches the command and result channels of the slot allocator. It keeps its
// own copy of the slot pool, works out the results of every accepted
// transaction and compares each strobed result against the oldest one due.
// ----------------------------------------------------------------------------
module slot_allocator_with_key_lookup_checker
    import sa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_busy,
    input  wire logic [OP_W-1:0]   i_operation,
    input  wire logic [SLOT_W-1:0] i_slot_number,
    input  wire logic [HALF_W-1:0] i_source_entity,
    input  wire logic [HALF_W-1:0] i_sequence_number,
    input  wire logic              i_valid,
    input  wire logic              i_found,
    input  wire logic [SLOT_W-1:0] i_slot_result,
    input  wire logic [CNT_W-1:0]  i_busy_count,
    input  wire logic              i_last,
    output int                     o_fail_count,
    output int                     o_pending
);

    // one result as the block should present it
    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  count;
        logic              last;
    } t_outcome;

    t_outcome          due_outcomes[$];
    logic [NUM_SLOTS-1:0] pool_in_use = '0;
    logic [KEY_W-1:0]  pool_key [NUM_SLOTS];
    int                fails = 0;

    function automatic logic [CNT_W-1:0] slots_in_use(input logic [NUM_SLOTS-1:0] m);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            n = n + CNT_W'(m[i]);
        end
        return n;
    endfunction

    task automatic add_outcome(input logic f, input logic [SLOT_W-1:0] s,
                               input logic [CNT_W-1:0] c, input logic l);
        t_outcome o;
        o.found = f;
        o.slot  = s;
        o.count = c;
        o.last  = l;
        due_outcomes.push_back(o);
    endtask

    // update the pool copy for one transaction and queue what it yields
    task automatic apply_pool_command(input t_op op, input logic [SLOT_W-1:0] slot,
                                      input logic [KEY_W-1:0] key);
        int               hit;
        int               k;
        logic [CNT_W-1:0] n;
        hit = -1;
        case (op)
            OP_ALLOC: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (!pool_in_use[i] && hit < 0) hit = i;
                end
                if (hit >= 0) begin
                    pool_in_use[hit] = 1'b1;
                    pool_key[hit]    = key;
                    add_outcome(1'b1, SLOT_W'(hit), slots_in_use(pool_in_use), 1'b1);
                end else begin
                    add_outcome(1'b0, '0, slots_in_use(pool_in_use), 1'b1);
                end
            end
            OP_FREE: begin
                if (int'(slot) < NUM_SLOTS) begin
                    pool_in_use[slot[IDX_W-1:0]] = 1'b0;
                    add_outcome(1'b1, slot, slots_in_use(pool_in_use), 1'b1);
                end else begin
                    add_outcome(1'b0, '0, slots_in_use(pool_in_use), 1'b1);
                end
            end
            OP_LOOKUP: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (pool_in_use[i] && pool_key[i] == key && hit < 0) hit = i;
                end
                if (hit >= 0) begin
                    add_outcome(1'b1, SLOT_W'(hit), slots_in_use(pool_in_use), 1'b1);
                end else begin
                    add_outcome(1'b0, '0, slots_in_use(pool_in_use), 1'b1);
                end
            end
            default: begin
                // walk: one result per slot in use, or a single miss when empty
                n = slots_in_use(pool_in_use);
                k = 0;
                if (n == 0) begin
                    add_outcome(1'b0, '0, '0, 1'b1);
                end else begin
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (pool_in_use[i]) begin
                            k++;
                            add_outcome(1'b1, SLOT_W'(i), n, k == int'(n));
                        end
                    end
                end
            end
        endcase
    endtask

    // results are taken before new commands, so a result never meets its own
    always @(posedge i_clk) begin : watch
        t_outcome want;
        if (!i_rst_n) begin
            pool_in_use = '0;
            due_outcomes.delete();
        end else begin
            if (i_valid) begin
                if (due_outcomes.size() == 0) begin
                    $error("result with no transaction outstanding: slot %0d", i_slot_result);
                    fails++;
                end else begin
                    want = due_outcomes.pop_front();
                    if (i_found !== want.found) begin
                        $error("found: expected %0d, actual %0d", want.found, i_found);
                        fails++;
                    end
                    if (i_slot_result !== want.slot) begin
                        $error("slot_result: expected %0d, actual %0d", want.slot,
                               i_slot_result);
                        fails++;
                    end
                    if (i_busy_count !== want.count) begin
                        $error("busy_count: expected %0d, actual %0d", want.count,
                               i_busy_count);
                        fails++;
                    end
                    if (i_last !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, i_last);
                        fails++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                apply_pool_command(t_op'(i_operation), i_slot_number,
                                   {i_source_entity, i_sequence_number});
            end
        end
        o_pending    = due_outcomes.size();
        o_fail_count = fails;
    end

endmodule

// ===== tb/slot_allocator_with_key_lookup_tb.sv =====
// ----------------------------------------------------------------------------
// slot_allocator_with_key_lookup_tb
// Drives allocate, free, lookup and walk transactions into the slot allocator:
// a directed run over the corner cases, then phases that fill, drain and mix
// the pool with random keys and random idle gaps. The checker beside the block
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module slot_allocator_with_key_lookup_tb;
    import sa_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 420;
    localparam int PHASE_LEN    = 40;
    localparam int KEY_HISTORY  = 24;
    localparam int DRAIN_CYCLES = 40;

    typedef enum int {
        PH_FILL,
        PH_DRAIN,
        PH_MIXED
    } t_phase;

    logic              clk               = 1'b0;
    logic              rst_n             = 1'b0;
    logic              start             = 1'b0;
    logic              busy;
    logic [OP_W-1:0]   operation         = '0;
    logic [SLOT_W-1:0] slot_number       = '0;
    logic [HALF_W-1:0] source_entity     = '0;
    logic [HALF_W-1:0] sequence_number   = '0;
    logic              valid;
    logic              found;
    logic [SLOT_W-1:0] slot_result;
    logic [CNT_W-1:0]  busy_count;
    logic              last;
    int                fail_count;
    int                pending;
    int                cycle_count       = 0;
    logic              no_idle           = 1'b0;
    logic [KEY_W-1:0]  used_keys[$];

    slot_allocator_with_key_lookup u_top (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_start           (start),
        .o_busy            (busy),
        .i_operation       (operation),
        .i_slot_number     (slot_number),
        .i_source_entity   (source_entity),
        .i_sequence_number (sequence_number),
        .o_valid           (valid),
        .o_found           (found),
        .o_slot_result     (slot_result),
        .o_busy_count      (busy_count),
        .o_last            (last)
    );

    slot_allocator_with_key_lookup_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_start           (start),
        .i_busy            (busy),
        .i_operation       (operation),
        .i_slot_number     (slot_number),
        .i_source_entity   (source_entity),
        .i_sequence_number (sequence_number),
        .i_valid           (valid),
        .i_found           (found),
        .i_slot_result     (slot_result),
        .i_busy_count      (busy_count),
        .i_last            (last),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    // clock
    always #2 clk = ~clk;

    // run time guard
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // present one transaction and hold it until the block takes it
    task automatic send_command(input t_op op, input logic [SLOT_W-1:0] slot,
                                input logic [KEY_W-1:0] key);
        start           <= 1'b1;
        operation       <= op;
        slot_number     <= slot;
        source_entity   <= key[KEY_W-1:HALF_W];
        sequence_number <= key[HALF_W-1:0];
        do @(posedge clk); while (busy);
        if (op == OP_ALLOC) begin
            used_keys.push_back(key);
            if (used_keys.size() > KEY_HISTORY) void'(used_keys.pop_front());
        end
    endtask

    // mostly short gaps, a few long ones, with noise on the idle command lines
    task automatic idle_gap();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) n = 0;
        else if (r < 90) n = $urandom_range(1, 3);
        else n = $urandom_range(8, 30);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) begin
                operation       <= OP_W'($urandom);
                slot_number     <= SLOT_W'($urandom);
                source_entity   <= $urandom;
                sequence_number <= $urandom;
                @(posedge clk);
            end
        end
    endtask

    // lookup keys: mostly stored ones, some one bit away, some fresh
    function automatic logic [KEY_W-1:0] pick_lookup_key();
        int               r;
        logic [KEY_W-1:0] k;
        r = $urandom_range(0, 9);
        if (used_keys.size() == 0 || r >= 8) begin
            k = {$urandom, $urandom};
        end else begin
            k = used_keys[$urandom_range(0, used_keys.size() - 1)];
            if (r >= 6) k[$urandom_range(0, KEY_W - 1)] ^= 1'b1;
        end
        return k;
    endfunction

    // allocation keys: fresh, with some repeats so lookups meet duplicates
    function automatic logic [KEY_W-1:0] pick_alloc_key();
        if (used_keys.size() > 0 && $urandom_range(0, 3) == 0) begin
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        end
        return {$urandom, $urandom};
    endfunction

    function automatic t_op pick_operation(input t_phase ph);
        int r;
        r = $urandom_range(0, 99);
        case (ph)
            PH_FILL: begin
                if (r < 70) return OP_ALLOC;
                if (r < 78) return OP_FREE;
                if (r < 95) return OP_LOOKUP;
                return OP_WALK;
            end
            PH_DRAIN: begin
                if (r < 10) return OP_ALLOC;
                if (r < 75) return OP_FREE;
                if (r < 95) return OP_LOOKUP;
                return OP_WALK;
            end
            default: begin
                if (r < 35) return OP_ALLOC;
                if (r < 65) return OP_FREE;
                if (r < 92) return OP_LOOKUP;
                return OP_WALK;
            end
        endcase
    endfunction

    // stimulus and verdict
    initial begin : stimulus
        t_phase            ph;
        t_op               op;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  key;
        ph = PH_FILL;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corner cases on an empty, then lightly used pool
        send_command(OP_WALK,   '0, '0);             idle_gap();
        send_command(OP_LOOKUP, '0, '0);             idle_gap();
        send_command(OP_FREE,   '1, {$urandom, $urandom}); idle_gap();
        send_command(OP_FREE,   SLOT_W'(NUM_SLOTS), '0); idle_gap();
        send_command(OP_FREE,   SLOT_W'(NUM_SLOTS - 1), '1); idle_gap();
        send_command(OP_ALLOC,  '1, '0);             idle_gap();
        send_command(OP_ALLOC,  '0, '1);             idle_gap();
        send_command(OP_ALLOC,  '0, {32'hFFFF_FFFF, 32'h0}); idle_gap();
        send_command(OP_ALLOC,  '0, '0);             idle_gap();
        send_command(OP_LOOKUP, '0, '1);             idle_gap();
        send_command(OP_LOOKUP, '1, '0);             idle_gap();
        send_command(OP_LOOKUP, '0, {32'h0, 32'hFFFF_FFFF}); idle_gap();
        send_command(OP_WALK,   '0, '0);             idle_gap();
        send_command(OP_FREE,   '0, '0);             idle_gap();
        send_command(OP_LOOKUP, '0, '0);             idle_gap();
        send_command(OP_FREE,   6'd3, '0);           idle_gap();
        send_command(OP_LOOKUP, '0, '0);             idle_gap();
        send_command(OP_WALK,   '0, '0);             idle_gap();
        send_command(OP_FREE,   6'd1, '0);           idle_gap();
        send_command(OP_FREE,   6'd2, '0);           idle_gap();
        send_command(OP_WALK,   '0, '0);             idle_gap();

        // random phases; the first one fills the pool past full
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % PHASE_LEN == 0) begin
                if (n > 0) ph = t_phase'($urandom_range(0, 2));
                no_idle = ($urandom_range(0, 3) == 0);
            end
            op   = pick_operation(ph);
            slot = SLOT_W'($urandom);
            key  = {$urandom, $urandom};
            case (op)
                OP_ALLOC:  key = pick_alloc_key();
                OP_LOOKUP: key = pick_lookup_key();
                OP_FREE: begin
                    if ($urandom_range(0, 99) < 85) begin
                        slot = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
                    end
                end
                default: ;
            endcase
            send_command(op, slot, key);
            idle_gap();
        end

        // let every outstanding result come out, then watch for strays
        start <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
